// ===== rtl/length_prefix_list_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the length prefix list deframer
// Concurrent assertion wrappers; defining NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIX_LIST_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIX_LIST_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define LPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check on every clock edge, reset included.
`define LPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LPD_ASSERT(lbl, prop, msg)
`define LPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length prefix list deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int LenWidthDef   = 32;
  localparam int QueueDepthDef = 4;

  localparam logic [7:0] LenEnd = 8'hff;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StTrunc = 2'd1,
    StOvf   = 2'd2
  } lpd_status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       msg_last;
  } lpd_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        obj_end;
    lpd_status_e status;
  } lpd_out_t;

endpackage

// ===== rtl/lpd_front.sv =====
// ----------------------------------------------------------------------------
// lpd_front
// Parses headers and payload bytes, one word per cycle while accept_i is high, and produces results.
// ----------------------------------------------------------------------------
`include "length_prefix_list_deframer_defines.svh"

module lpd_front #(
  parameter int LenWidth = lpd_pkg::LenWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  lpd_pkg::lpd_in_t in_item_i,
  output logic             res_valid_o,
  output lpd_pkg::lpd_out_t res_o
);

  localparam int PW = LenWidth + 8;

  typedef enum logic [1:0] {
    PhHeader  = 2'b01,
    PhPayload = 2'b10
  } lpd_phase_e;

  lpd_phase_e          phase_q, phase_d;
  logic [LenWidth-1:0] acc_q, acc_d;
  logic [LenWidth-1:0] w_q, w_d;
  logic                big_q, big_d;
  logic [LenWidth-1:0] left_q, left_d;
  logic                ovf_q, ovf_d;

  logic [PW-1:0]       prod;
  logic [PW-1:0]       wx;
  logic [LenWidth:0]   sum;
  logic                digit_ovf;
  logic [LenWidth-1:0] left_dec;
  logic                pay_end;
  logic                last;

  assign last = in_item_i.msg_last;

  // digit times weight, and the next weight times 255
  assign prod      = {{LenWidth{1'b0}}, in_item_i.in_byte} * {8'b0, w_q};
  assign wx        = {w_q, 8'b0} - {8'b0, w_q};
  assign sum       = {1'b0, acc_q} + {1'b0, prod[LenWidth-1:0]};
  assign digit_ovf = big_q || (prod[PW-1:LenWidth] != '0) || sum[LenWidth];

  assign left_dec = (left_q != '0) ? left_q - LenWidth'(1) : '0;
  assign pay_end  = (left_dec == '0) || last;

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    w_d         = w_q;
    big_d       = big_q;
    left_d      = left_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      unique case (phase_q)
        PhHeader: begin
          if (in_item_i.in_byte != lpd_pkg::LenEnd) begin
            if ((in_item_i.in_byte != 8'd0) && !ovf_q) begin
              if (digit_ovf) begin
                ovf_d = 1'b1;
                acc_d = '1;
              end else begin
                acc_d = sum[LenWidth-1:0];
              end
            end
            if (!big_q) begin
              if (wx[PW-1:LenWidth] != '0) begin
                big_d = 1'b1;
              end else begin
                w_d = wx[LenWidth-1:0];
              end
            end
            if (last) begin
              res_valid_o  = 1'b1;
              res_o.obj_end = 1'b1;
              res_o.status  = lpd_pkg::StTrunc;
            end
          end else begin
            acc_d = '0;
            w_d   = LenWidth'(1);
            big_d = 1'b0;
            if (acc_q == '0) begin
              res_valid_o   = 1'b1;
              res_o.obj_end = 1'b1;
              res_o.status  = ovf_q ? lpd_pkg::StOvf : lpd_pkg::StOk;
            end else if (last) begin
              res_valid_o   = 1'b1;
              res_o.obj_end = 1'b1;
              res_o.status  = lpd_pkg::StTrunc;
            end else begin
              phase_d = PhPayload;
              left_d  = acc_q;
            end
          end
        end
        PhPayload: begin
          res_valid_o    = 1'b1;
          res_o.out_byte = in_item_i.in_byte;
          res_o.has_byte = 1'b1;
          res_o.obj_end  = pay_end;
          if ((left_dec != '0) && last) begin
            res_o.status = lpd_pkg::StTrunc;
          end else begin
            res_o.status = ovf_q ? lpd_pkg::StOvf : lpd_pkg::StOk;
          end
          left_d = left_dec;
          if (pay_end) begin
            phase_d = PhHeader;
            left_d  = '0;
            ovf_d   = 1'b0;
          end
        end
        default: phase_d = PhHeader;
      endcase
      // message end: drop all state back to reset values
      if (last) begin
        phase_d = PhHeader;
        acc_d   = '0;
        w_d     = LenWidth'(1);
        big_d   = 1'b0;
        left_d  = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      acc_q   <= '0;
      w_q     <= LenWidth'(1);
      big_q   <= 1'b0;
      left_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      w_q     <= w_d;
      big_q   <= big_d;
      left_q  <= left_d;
      ovf_q   <= ovf_d;
    end
  end

  `LPD_ASSERT(a_payload_owes, (phase_q == PhPayload) |-> (left_q != '0), "payload with no bytes owed")
  `LPD_ASSERT(a_ovf_saturated, (phase_q == PhHeader && ovf_q) |-> (acc_q == '1), "overflow without saturation")
  `LPD_ASSERT(a_last_clears, (accept_i && last) |=> (phase_q == PhHeader && !ovf_q && acc_q == '0), "message end left state")

endmodule

// ===== rtl/lpd_queue.sv =====
// ----------------------------------------------------------------------------
// lpd_queue
// Result queue between the parser and the output port.
// ----------------------------------------------------------------------------
`include "length_prefix_list_deframer_defines.svh"

module lpd_queue #(
  parameter int Depth = lpd_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lpd_pkg::lpd_out_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output lpd_pkg::lpd_out_t data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  lpd_pkg::lpd_out_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              wr, rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd && !wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // wrap at the last slot so any depth works
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  `LPD_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count beyond depth")
  `LPD_ASSERT(a_cnt_inc, (wr && !rd) |=> (cnt_q == $past(cnt_q) + CntW'(1)), "queue count lost a write")
  `LPD_ASSERT(a_empty_ptrs, empty_o |-> (rd_ptr_q == wr_ptr_q), "empty queue with pointers apart")

endmodule

// ===== rtl/length_prefix_list_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefix_list_deframer
// Result path: an accepted word's result is written into the queue register,
//   then drives the out ports (empty low) if the queue held nothing older.
// Throughput: one input word per cycle while full is low; the header digit
//   update in the parser (an 8 x LEN_WIDTH multiply and add) is combinational.
// Reset: asynchronous, active low; returns to the header phase, empties queue.
// ----------------------------------------------------------------------------
module length_prefix_list_deframer #(
  parameter int LEN_WIDTH   = lpd_pkg::LenWidthDef,
  parameter int QUEUE_DEPTH = lpd_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input word channel
  input  logic              push,
  output logic              full,
  input  lpd_pkg::lpd_in_t  in_item_i,
  // result word channel
  output logic              empty,
  input  logic              pop,
  output lpd_pkg::lpd_out_t out_item_o
);

  // Front: header digits accumulate as byte * 255^k with saturation; payload
  // words count down the owed length. Each accepted word yields zero or one
  // result word, written straight into the queue.
  logic              accept;
  logic              res_valid;
  lpd_pkg::lpd_out_t res;

  // accept whenever the queue has a free slot, so the parser never waits on
  // a pending result unless the queue is full
  assign accept = push && !full;

  lpd_front #(
    .LenWidth (LEN_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Back: results wait here until the consumer pops them; the head entry
  // drives the out ports directly.
  lpd_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_item_o)
  );

endmodule
